FILE: hw/rtl/bvf_pkg.sv
`default_nettype none

package bvf_pkg;

	// Fixed-point layout of the filter accumulator.
	localparam int FRAC_BITS = 4;
	localparam int VOLT_W    = 13;
	localparam int ACC_W     = VOLT_W + FRAC_BITS;

	// Input and register field widths.
	localparam int TICK_W     = 32;
	localparam int ADC_WORD_W = 16;
	localparam int ADC_SHIFT  = 6;
	localparam int ADC_W      = ADC_WORD_W - ADC_SHIFT;
	localparam int INTERVAL_W = 16;
	localparam int THRESH_W   = 13;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	// Filter coefficients: acc = (acc * 29 + sample) / 30.
	localparam int ADC_SCALE = 5;
	localparam int DECAY_NUM = 29;
	localparam int DECAY_DEN = 30;
	localparam int HALF_DEN  = DECAY_DEN / 2;

	// Width of acc * 29 + sample; 30 * max accumulator needs five extra bits.
	localparam int SUM_W  = ACC_W + 5;
	localparam int HALF_W = SUM_W - 1;

	// Reciprocal of 15 for the halved sum; the estimate is at most one low.
	localparam int RECIP_SHIFT = HALF_W + 1;
	localparam int RECIP_W     = RECIP_SHIFT - 3;
	localparam int PROD_W      = HALF_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'((64'd1 << RECIP_SHIFT) / HALF_DEN);

	// Register reset values.
	localparam logic [INTERVAL_W-1:0] SAMPLE_INTERVAL_RST  = INTERVAL_W'(16'h007B);
	localparam logic [THRESH_W-1:0]   LOW_THRESHOLD_RST    = THRESH_W'(16'h09C4);
	localparam logic [THRESH_W-1:0]   CHARGE_THRESHOLD_RST = THRESH_W'(16'h0988);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_INTERVAL  = 2'd0,
		REG_LOW_THRESHOLD    = 2'd1,
		REG_CHARGE_THRESHOLD = 2'd2
	} bvf_reg_t;

	typedef struct packed {
		logic [INTERVAL_W-1:0] sample_interval;
		logic [THRESH_W-1:0]   low_threshold;
		logic [THRESH_W-1:0]   charge_threshold;
	} bvf_cfg_t;

	typedef struct packed {
		logic                needs_charge;
		logic                low_battery;
		logic                updated;
		logic [VOLT_W-1:0]   volt_avg;
	} bvf_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bvf_cfg_regs.sv
`default_nettype none

module bvf_cfg_regs
	import bvf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output bvf_cfg_t                   cfg
);

	bvf_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_interval  <= SAMPLE_INTERVAL_RST;
			cfg_q.low_threshold    <= LOW_THRESHOLD_RST;
			cfg_q.charge_threshold <= CHARGE_THRESHOLD_RST;
		end else if (wr_en) begin
			unique case (bvf_reg_t'(wr_index))
				REG_SAMPLE_INTERVAL: begin
					cfg_q.sample_interval <= wr_data[INTERVAL_W-1:0];
				end
				REG_LOW_THRESHOLD: begin
					cfg_q.low_threshold <= wr_data[THRESH_W-1:0];
				end
				REG_CHARGE_THRESHOLD: begin
					cfg_q.charge_threshold <= wr_data[THRESH_W-1:0];
				end
				default: begin
					// Unmapped index: the write is dropped.
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/bvf_update.sv
`default_nettype none

module bvf_update
	import bvf_pkg::*;
(
	input  wire logic [TICK_W-1:0]     tick_count,
	input  wire logic [ADC_WORD_W-1:0] adc_word,
	input  wire bvf_cfg_t              cfg,
	input  wire logic [ACC_W-1:0]      acc,
	input  wire logic [TICK_W-1:0]     last_tick,
	output logic [ACC_W-1:0]           acc_next,
	output logic [TICK_W-1:0]          last_tick_next,
	output bvf_result_t                result
);

	logic [ADC_W-1:0]   sample_raw;
	logic [VOLT_W-1:0]  scaled;
	logic [ACC_W-1:0]   sample_fx;
	logic               seed;
	logic [ACC_W-1:0]   acc_a;
	logic [TICK_W-1:0]  last_a;
	logic [TICK_W-1:0]  tick_diff;
	logic               do_update;
	logic [SUM_W-1:0]   sum;
	logic [HALF_W-1:0]  half;
	logic [PROD_W-1:0]  prod;
	logic [HALF_W-1:0]  q_est;
	logic [HALF_W-1:0]  rem;
	logic [HALF_W-1:0]  quot;
	logic [VOLT_W-1:0]  filt;

	always_comb begin
		sample_raw = adc_word[ADC_WORD_W-1:ADC_SHIFT];
		scaled     = VOLT_W'(sample_raw) * VOLT_W'(ADC_SCALE);
		sample_fx  = ACC_W'({scaled, {FRAC_BITS{1'b0}}});

		// A zero accumulator means unseeded: load the sample and restart the interval.
		seed   = (acc == '0);
		acc_a  = seed ? sample_fx : acc;
		last_a = seed ? tick_count : last_tick;

		tick_diff = tick_count - last_a;
		do_update = tick_diff > TICK_W'(cfg.sample_interval);

		// (acc * 29 + sample) / 30 as ((sum >> 1) / 15), reciprocal then one correction.
		sum   = SUM_W'(acc_a) * SUM_W'(DECAY_NUM) + SUM_W'(sample_fx);
		half  = sum[SUM_W-1:1];
		prod  = PROD_W'(half) * PROD_W'(RECIP_MUL);
		q_est = HALF_W'(prod >> RECIP_SHIFT);
		rem   = half - q_est * HALF_W'(HALF_DEN);
		quot  = (rem >= HALF_W'(HALF_DEN)) ? q_est + HALF_W'(1) : q_est;

		acc_next       = do_update ? quot[ACC_W-1:0] : acc_a;
		last_tick_next = do_update ? tick_count : last_a;

		filt                = acc_next[ACC_W-1:FRAC_BITS];
		result.volt_avg     = filt;
		result.updated      = seed | do_update;
		result.low_battery  = filt < cfg.low_threshold;
		result.needs_charge = filt < cfg.charge_threshold;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/battery_voltage_ema_filter.sv
// The result is offered on the master side once the item moves from the input register
// to the output register, which it does when that register is empty or being emptied.
// Throughput: one item per cycle unless m_tready stalls; the acc_q update is combinational.
// Reset (arst_n low, asynchronous): the filter is unseeded, the stored tick is zero, both
// stages are empty and the registers return to interval 123, thresholds 2500 and 2440.
`default_nettype none

module battery_voltage_ema_filter
	import bvf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	// Input items. s_tdata, from bit 0: tick_count[31:0], adc_word[15:0].
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [47:0]           s_tdata,

	// Result items. m_tdata, from bit 0: volt_avg[12:0], updated,
	// low_battery, needs_charge.
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [15:0]                m_tdata,

	// Configuration writes, always accepted.
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	bvf_cfg_t cfg;

	// Input register: the accepted item waits here until the output register is free.
	logic                  valid_s1;
	logic [TICK_W-1:0]     tick_s1;
	logic [ADC_WORD_W-1:0] adc_s1;

	// Output register holding the finished result.
	logic                  valid_s2;
	bvf_result_t           result_s2;

	// Filter state.
	logic [ACC_W-1:0]      acc_q;
	logic [TICK_W-1:0]     last_tick_q;

	logic [ACC_W-1:0]      acc_next;
	logic [TICK_W-1:0]     last_tick_next;
	bvf_result_t           result_next;
	logic                  advance;
	logic                  in_fire;

	assign cfg_ready = 1'b1;

	bvf_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bvf_update u_update (
		.tick_count     (tick_s1),
		.adc_word       (adc_s1),
		.cfg            (cfg),
		.acc            (acc_q),
		.last_tick      (last_tick_q),
		.acc_next       (acc_next),
		.last_tick_next (last_tick_next),
		.result         (result_next)
	);

	// The item in the input register is processed, and the state committed, in the
	// cycle it moves into the output register. That happens whenever the output
	// register is empty or its result is being taken, so both stages keep flowing.
	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign in_fire  = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			tick_s1 <= s_tdata[TICK_W-1:0];
			adc_s1  <= s_tdata[TICK_W+ADC_WORD_W-1:TICK_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			acc_q       <= '0;
			last_tick_q <= '0;
		end else begin
			if (advance) begin
				valid_s2    <= 1'b1;
				acc_q       <= acc_next;
				last_tick_q <= last_tick_next;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;

	// A processed item always leaves a result in the output register.
	a_advance_fills_output: assert property (
		@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2
	) else $error("processed item did not reach the output register");

	// A non-zero sample can never leave the filter unseeded.
	a_nonzero_sample_seeds: assert property (
		@(posedge clk) disable iff (!arst_n)
		(advance && adc_s1[ADC_WORD_W-1:ADC_SHIFT] != '0) |=> (acc_q != '0)
	) else $error("accumulator zero after a non-zero sample");

	// Whenever a result reports a seed or update, the stored tick is that item's tick.
	a_update_stores_tick: assert property (
		@(posedge clk) disable iff (!arst_n)
		(advance && result_next.updated) |=> (last_tick_q == $past(tick_s1))
	) else $error("stored tick does not follow an update");

endmodule

`default_nettype wire
